// ----- hdl/smrc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// smrc_pkg
// Shared constants, types and helpers of the clockwise matrix rotator.
// ----------------------------------------------------------------------------
package smrc_pkg;

    localparam int MAX_DIM      = 8;
    localparam int DIM_W        = 4;
    localparam int VAL_W        = 32;
    localparam int STORE_DEPTH  = MAX_DIM * MAX_DIM;
    localparam int CNT_W        = $clog2(STORE_DEPTH);
    localparam int TOT_W        = $clog2(STORE_DEPTH + 1);
    localparam int ROW_W        = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int N_BANKS      = 2;
    localparam int BANK_W       = $clog2(N_BANKS);
    localparam int RAM_DEPTH    = N_BANKS * STORE_DEPTH;
    localparam int RAM_ADDR_W   = $clog2(RAM_DEPTH);
    localparam int BUSY_W       = $clog2(N_BANKS + 1);
    localparam int TOKQ_DEPTH   = N_BANKS;
    localparam int TOKQ_PTR_W   = $clog2(TOKQ_DEPTH);
    localparam int TOKQ_CNT_W   = $clog2(TOKQ_DEPTH + 1);
    localparam int OFIFO_DEPTH  = 4;
    localparam int OFIFO_PTR_W  = $clog2(OFIFO_DEPTH);
    localparam int OFIFO_CNT_W  = $clog2(OFIFO_DEPTH + 1);

    typedef struct packed {
        logic [BANK_W-1:0] bank;
        logic [DIM_W-1:0]  n;
        logic [TOT_W-1:0]  total;
    } t_tok;

    typedef struct packed {
        logic                  en;
        logic [RAM_ADDR_W-1:0] addr;
        logic [VAL_W-1:0]      data;
    } t_wr;

    typedef struct packed {
        logic                  en;
        logic [RAM_ADDR_W-1:0] addr;
    } t_rd;

    function automatic logic [DIM_W-1:0] side_len(input logic [DIM_W-1:0] dim);
        logic [DIM_W-1:0] n;
        n = dim;
        if (n == '0) begin
            n = DIM_W'(1);
        end else if (n > DIM_W'(MAX_DIM)) begin
            n = DIM_W'(MAX_DIM);
        end
        return n;
    endfunction

endpackage
`default_nettype wire

// ----- hdl/smrc_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// smrc_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module smrc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

// ----- hdl/smrc_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// smrc_front
// Load side: holds the side length, writes elements into the free bank and
// posts a token for each completed matrix.
// ----------------------------------------------------------------------------
module smrc_front (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [smrc_pkg::DIM_W-1:0]   i_cfg_data,
    input  wire logic                         push,
    output logic                              full,
    input  wire logic [smrc_pkg::VAL_W-1:0]   i_value,
    input  wire logic                         i_release,
    output smrc_pkg::t_wr                     o_wr,
    output logic                              o_tok_push,
    output smrc_pkg::t_tok                    o_tok
);
    import smrc_pkg::*;

    logic [DIM_W-1:0]  r_n;
    logic [TOT_W-1:0]  r_total;
    logic [CNT_W-1:0]  r_cnt;
    logic [BANK_W-1:0] r_bank;
    logic [BUSY_W-1:0] r_busy;

    logic             accept;
    logic             done;
    logic [TOT_W-1:0] cnt_inc;
    logic [DIM_W-1:0] cfg_n;

    assign full    = (r_busy == BUSY_W'(N_BANKS));
    assign accept  = push && !full && !i_cfg_we;
    assign cnt_inc = TOT_W'(r_cnt) + TOT_W'(1);
    assign done    = accept && (cnt_inc >= r_total);
    assign cfg_n   = side_len(i_cfg_data);

    assign o_wr.en    = accept;
    assign o_wr.addr  = {r_bank, r_cnt};
    assign o_wr.data  = i_value;
    assign o_tok_push = done;
    assign o_tok      = '{bank: r_bank, n: r_n, total: r_total};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n     <= DIM_W'(MAX_DIM);
            r_total <= TOT_W'(MAX_DIM * MAX_DIM);
            r_cnt   <= '0;
            r_bank  <= '0;
            r_busy  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_n     <= cfg_n;
                r_total <= TOT_W'(cfg_n) * TOT_W'(cfg_n);
                r_cnt   <= '0;
            end else if (done) begin
                r_cnt  <= '0;
                r_bank <= r_bank + BANK_W'(1);
            end else if (accept) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
            if (done && !i_release) begin
                r_busy <= r_busy + BUSY_W'(1);
            end else if (!done && i_release) begin
                r_busy <= r_busy - BUSY_W'(1);
            end
        end
    end

endmodule
`default_nettype wire

// ----- hdl/smrc_tokq.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// smrc_tokq
// Short queue of completed-matrix tokens between load and emit sides.
// ----------------------------------------------------------------------------
module smrc_tokq (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire smrc_pkg::t_tok i_tok,
    output logic       o_full,
    output logic       o_valid,
    input  wire logic  i_pop,
    output smrc_pkg::t_tok o_tok
);
    import smrc_pkg::*;

    t_tok                  r_q [TOKQ_DEPTH];
    logic [TOKQ_PTR_W-1:0] r_wp;
    logic [TOKQ_PTR_W-1:0] r_rp;
    logic [TOKQ_CNT_W-1:0] r_cnt;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_cnt == TOKQ_CNT_W'(TOKQ_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_tok   = r_q[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_q[r_wp] <= i_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + TOKQ_PTR_W'(1);
            end
            if (do_pop) begin
                r_rp <= r_rp + TOKQ_PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + TOKQ_CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - TOKQ_CNT_W'(1);
            end
        end
    end

endmodule
`default_nettype wire

// ----- hdl/smrc_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// smrc_back
// Emit side: walks the rotated read order of one bank and queues results.
// ----------------------------------------------------------------------------
module smrc_back (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_tok_valid,
    input  wire smrc_pkg::t_tok             i_tok,
    output logic                            o_tok_pop,
    output smrc_pkg::t_rd                   o_rd,
    input  wire logic [smrc_pkg::VAL_W-1:0] i_rdata,
    output logic                            o_release,
    output logic                            empty,
    input  wire logic                       pop,
    output logic [smrc_pkg::VAL_W-1:0]      o_value_res,
    output logic                            o_last
);
    import smrc_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_RUN
    } t_state;

    t_state            r_state;
    logic [BANK_W-1:0] r_bank;
    logic [DIM_W-1:0]  r_n;
    logic [ROW_W-1:0]  r_row;
    logic [ROW_W-1:0]  r_col;
    logic [CNT_W-1:0]  r_rowbase;
    logic [CNT_W-1:0]  r_src;
    logic              r_rd_vld;
    logic              r_rd_last;
    logic              r_release;

    logic [VAL_W-1:0]       r_fdata [OFIFO_DEPTH];
    logic                   r_flast [OFIFO_DEPTH];
    logic [OFIFO_PTR_W-1:0] r_fwp;
    logic [OFIFO_PTR_W-1:0] r_frp;
    logic [OFIFO_CNT_W-1:0] r_fcnt;

    logic                 issue;
    logic                 col_end;
    logic                 row_end;
    logic                 is_last;
    logic                 f_pop;
    logic [OFIFO_CNT_W:0] pending;
    logic [CNT_W-1:0]     start_base;

    assign pending    = (OFIFO_CNT_W+1)'(r_fcnt) + (OFIFO_CNT_W+1)'(r_rd_vld);
    assign issue      = (r_state == S_RUN) && (pending < (OFIFO_CNT_W+1)'(OFIFO_DEPTH));
    assign col_end    = (DIM_W'(r_col) == r_n - DIM_W'(1));
    assign row_end    = (DIM_W'(r_row) == r_n - DIM_W'(1));
    assign is_last    = col_end && row_end;
    assign start_base = CNT_W'(i_tok.total - TOT_W'(i_tok.n));
    assign o_tok_pop  = (r_state == S_IDLE) && i_tok_valid;

    assign o_rd.en    = issue;
    assign o_rd.addr  = {r_bank, r_src};
    assign o_release  = r_release;

    assign empty       = (r_fcnt == '0);
    assign f_pop       = pop && !empty;
    assign o_value_res = r_fdata[r_frp];
    assign o_last      = r_flast[r_frp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_rd_vld  <= 1'b0;
            r_release <= 1'b0;
        end else begin
            r_rd_vld  <= issue;
            r_release <= issue && is_last;
            unique case (r_state)
                S_IDLE: begin
                    if (i_tok_valid) begin
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    if (issue && is_last) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_last <= is_last;
        if (o_tok_pop) begin
            r_bank    <= i_tok.bank;
            r_n       <= i_tok.n;
            r_row     <= '0;
            r_col     <= '0;
            r_rowbase <= start_base;
            r_src     <= start_base;
        end else if (issue) begin
            if (col_end) begin
                r_col     <= '0;
                r_row     <= r_row + ROW_W'(1);
                r_rowbase <= r_rowbase + CNT_W'(1);
                r_src     <= r_rowbase + CNT_W'(1);
            end else begin
                r_col <= r_col + ROW_W'(1);
                r_src <= r_src - CNT_W'(r_n);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_rd_vld) begin
            r_fdata[r_fwp] <= i_rdata;
            r_flast[r_fwp] <= r_rd_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwp  <= '0;
            r_frp  <= '0;
            r_fcnt <= '0;
        end else begin
            if (r_rd_vld) begin
                r_fwp <= r_fwp + OFIFO_PTR_W'(1);
            end
            if (f_pop) begin
                r_frp <= r_frp + OFIFO_PTR_W'(1);
            end
            if (r_rd_vld && !f_pop) begin
                r_fcnt <= r_fcnt + OFIFO_CNT_W'(1);
            end else if (f_pop && !r_rd_vld) begin
                r_fcnt <= r_fcnt - OFIFO_CNT_W'(1);
            end
        end
    end

endmodule
`default_nettype wire

// ----- hdl/square_matrix_rotate_cw_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// square_matrix_rotate_cw_core
// Rotates a square matrix 90 degrees clockwise, elements in row-major order.
//
//   channel   direction  handshake         payload
//   elements  in         push / full       i_value
//   results   out        empty / pop       o_value_res, o_last
//   config    in         i_cfg_we          i_cfg_data (side length)
//
// One element loads per cycle, while full is low and no config write is
// made, into one of two store banks. A completed matrix is emitted at one
// result per cycle from its bank, while the result queue has room, as the next
// matrix loads into the other bank. The emit side idles between matrices; each
// token passes the token queue, then the bank is read into the result queue.
// full is high while both banks hold matrices not yet fully read from the store.
// Reset needs no clearing pass; the store is only read after being written.
// ----------------------------------------------------------------------------
module square_matrix_rotate_cw_core (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [smrc_pkg::DIM_W-1:0]   i_cfg_data,
    input  wire logic                         push,
    output logic                              full,
    input  wire logic signed [smrc_pkg::VAL_W-1:0] i_value,
    output logic                              empty,
    input  wire logic                         pop,
    output logic signed [smrc_pkg::VAL_W-1:0] o_value_res,
    output logic                              o_last
);
    import smrc_pkg::*;

    t_wr              wr;
    t_rd              rd;
    t_tok             tok_in;
    t_tok             tok_out;
    logic             tok_push;
    logic             tok_full;
    logic             tok_valid;
    logic             tok_pop;
    logic             release_bank;
    logic [VAL_W-1:0] rdata;
    logic [VAL_W-1:0] res;

    smrc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .push       (push),
        .full       (full),
        .i_value    (i_value),
        .i_release  (release_bank),
        .o_wr       (wr),
        .o_tok_push (tok_push),
        .o_tok      (tok_in)
    );

    smrc_tokq u_tokq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (tok_push),
        .i_tok   (tok_in),
        .o_full  (tok_full),
        .o_valid (tok_valid),
        .i_pop   (tok_pop),
        .o_tok   (tok_out)
    );

    smrc_ram #(
        .WIDTH (VAL_W),
        .DEPTH (RAM_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (wr.en),
        .i_waddr (wr.addr),
        .i_wdata (wr.data),
        .i_re    (rd.en),
        .i_raddr (rd.addr),
        .o_rdata (rdata)
    );

    smrc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tok_valid (tok_valid),
        .i_tok       (tok_out),
        .o_tok_pop   (tok_pop),
        .o_rd        (rd),
        .i_rdata     (rdata),
        .o_release   (release_bank),
        .empty       (empty),
        .pop         (pop),
        .o_value_res (res),
        .o_last      (o_last)
    );

    assign o_value_res = res;

`ifndef NO_ASSERTIONS
    a_no_rw_collide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr.en && rd.en) |-> (wr.addr != rd.addr))
        else $error("store read and write hit the same entry");

    a_tokq_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tok_push |-> !tok_full)
        else $error("token queue overflow");

    a_empty_after_reset: assert property (@(posedge i_clk)
        (i_rst_n && $past(!i_rst_n)) |-> empty)
        else $error("results present right after reset");
`endif

endmodule
`default_nettype wire
